// ----- rtl/tfn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths and types for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int CoordW = 24;   // Q12.12 vertex coordinate
  localparam int EdgeW  = 25;   // edge vector component
  localparam int ProdW  = 50;   // edge component product
  localparam int CrossW = 51;   // cross product component
  localparam int PosW   = 6;    // bit position within a cross magnitude
  localparam int UTop   = 30;   // normalized magnitude top bit
  localparam int UW     = 31;   // normalized magnitude
  localparam int SqW    = 62;   // square of a normalized magnitude
  localparam int LenW   = 64;   // squared length
  localparam int RootW  = 32;   // integer square root
  localparam int NumW   = 47;   // division numerator
  localparam int QW     = 16;   // quotient, 0..32768
  localparam int NormW  = 16;   // Q1.15 output
  localparam int FracW  = 15;   // fraction bits of Q1.15
  localparam logic [QW-1:0] QMax = 16'd32767;

  typedef struct packed {
    logic [2:0][UW-1:0] u;    // normalized magnitudes
    logic [2:0]         neg;  // sign of each cross component
    logic               deg;  // zero-length cross product
  } side_t;

endpackage

// ----- rtl/tfn_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_front
// Edge vectors, cross product, magnitude scaling and squared length.
// ----------------------------------------------------------------------------
module tfn_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [tfn_pkg::CoordW-1:0] first_x,
  input  logic signed [tfn_pkg::CoordW-1:0] first_y,
  input  logic signed [tfn_pkg::CoordW-1:0] first_z,
  input  logic signed [tfn_pkg::CoordW-1:0] second_x,
  input  logic signed [tfn_pkg::CoordW-1:0] second_y,
  input  logic signed [tfn_pkg::CoordW-1:0] second_z,
  input  logic signed [tfn_pkg::CoordW-1:0] third_x,
  input  logic signed [tfn_pkg::CoordW-1:0] third_y,
  input  logic signed [tfn_pkg::CoordW-1:0] third_z,
  output logic                              out_valid,
  output logic [tfn_pkg::LenW-1:0]          len2,
  output tfn_pkg::side_t                    side
);
  import tfn_pkg::*;

  logic [8:0] v;

  logic signed [EdgeW-1:0]  d1 [3];
  logic signed [EdgeW-1:0]  d2 [3];
  logic signed [ProdW-1:0]  p  [6];
  logic signed [CrossW-1:0] c  [3];
  logic [CrossW-1:0]        m4 [3];
  logic [CrossW-1:0]        m5 [3];
  logic [CrossW-1:0]        m6 [3];
  logic [CrossW-1:0]        orw;
  logic [PosW-1:0]          tb;
  logic [PosW-1:0]          tb_next;
  logic [2:0]               neg4, neg5, neg6;
  logic                     deg4, deg5, deg6;
  side_t                    side7, side8;
  logic [SqW-1:0]           sq [3];

  always_comb begin
    tb_next = '0;
    for (int b = 0; b < CrossW; b++) begin
      if (orw[b]) tb_next = PosW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // edges
      d1[0] <= EdgeW'(second_x) - EdgeW'(first_x);
      d1[1] <= EdgeW'(second_y) - EdgeW'(first_y);
      d1[2] <= EdgeW'(second_z) - EdgeW'(first_z);
      d2[0] <= EdgeW'(third_x) - EdgeW'(first_x);
      d2[1] <= EdgeW'(third_y) - EdgeW'(first_y);
      d2[2] <= EdgeW'(third_z) - EdgeW'(first_z);
      // products
      p[0] <= d1[1] * d2[2];
      p[1] <= d1[2] * d2[1];
      p[2] <= d1[2] * d2[0];
      p[3] <= d1[0] * d2[2];
      p[4] <= d1[0] * d2[1];
      p[5] <= d1[1] * d2[0];
      // cross components
      for (int i = 0; i < 3; i++) begin
        c[i] <= CrossW'(p[2*i]) - CrossW'(p[2*i+1]);
      end
      // magnitudes and signs
      for (int i = 0; i < 3; i++) begin
        m4[i]   <= c[i][CrossW-1] ? CrossW'(-c[i]) : CrossW'(c[i]);
        neg4[i] <= c[i][CrossW-1];
      end
      deg4 <= (c[0] == '0) && (c[1] == '0) && (c[2] == '0);
      // common top bit
      orw  <= m4[0] | m4[1] | m4[2];
      m5   <= m4;
      neg5 <= neg4;
      deg5 <= deg4;
      tb   <= tb_next;
      m6   <= m5;
      neg6 <= neg5;
      deg6 <= deg5;
      // scale so the largest magnitude tops out at bit 30
      for (int i = 0; i < 3; i++) begin
        if (tb >= PosW'(UTop)) begin
          side7.u[i] <= UW'(m6[i] >> (tb - PosW'(UTop)));
        end else begin
          side7.u[i] <= UW'(m6[i] << (PosW'(UTop) - tb));
        end
      end
      side7.neg <= neg6;
      side7.deg <= deg6;
      // squares and sum
      for (int i = 0; i < 3; i++) begin
        sq[i] <= SqW'(side7.u[i]) * SqW'(side7.u[i]);
      end
      side8 <= side7;
      len2  <= LenW'(sq[0]) + LenW'(sq[1]) + LenW'(sq[2]);
      side  <= side8;
    end
  end

  assign out_valid = v[8];

endmodule

// ----- rtl/tfn_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_sqrt
// Integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module tfn_sqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [tfn_pkg::LenW-1:0] len2,
  input  tfn_pkg::side_t           in_side,
  output logic                     out_valid,
  output logic [tfn_pkg::RootW-1:0] root,
  output tfn_pkg::side_t           out_side
);
  import tfn_pkg::*;

  logic [LenW-1:0] n    [RootW+1];
  logic [LenW-1:0] res  [RootW+1];
  side_t           sd   [RootW+1];
  logic [RootW:0]  v;

  assign n[0]   = len2;
  assign res[0] = '0;
  assign sd[0]  = in_side;
  assign v[0]   = in_valid;

  for (genvar k = 0; k < RootW; k++) begin : g_step
    localparam logic [LenW-1:0] Bit = LenW'(1) << (LenW - 2 - 2 * k);
    logic [LenW-1:0] trial;
    assign trial = res[k] + Bit;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[k+1] <= sd[k];
        if (n[k] >= trial) begin
          n[k+1]   <= n[k] - trial;
          res[k+1] <= (res[k] >> 1) + Bit;
        end else begin
          n[k+1]   <= n[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  assign out_valid = v[RootW];
  assign root      = res[RootW][RootW-1:0];
  assign out_side  = sd[RootW];

endmodule

// ----- rtl/tfn_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_div
// Rounded division of each magnitude by the length, sign and saturation.
// ----------------------------------------------------------------------------
module tfn_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [tfn_pkg::RootW-1:0]         root,
  input  tfn_pkg::side_t                    in_side,
  output logic                              out_valid,
  output logic signed [tfn_pkg::NormW-1:0]  normal_x,
  output logic signed [tfn_pkg::NormW-1:0]  normal_y,
  output logic signed [tfn_pkg::NormW-1:0]  normal_z,
  output logic                              degenerate
);
  import tfn_pkg::*;

  logic [2:0][NumW-1:0] rem [QW+1];
  logic [2:0][QW-1:0]   q   [QW+1];
  logic [RootW-1:0]     r   [QW+1];
  logic [2:0]           neg [QW+1];
  logic                 dg  [QW+1];
  logic [QW+1:0]        v;
  logic [2:0][NormW-1:0] nrm;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  // numerator: magnitude in Q.15 plus half the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= (NumW'(in_side.u[i]) << FracW) + NumW'(root >> 1);
        q[0][i]   <= '0;
      end
      r[0]   <= root;
      neg[0] <= in_side.neg;
      dg[0]  <= in_side.deg;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int Sh = QW - 1 - j;
    logic [NumW-1:0] dsh;
    assign dsh = NumW'(r[j]) << Sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem[j][i] >= dsh) begin
            rem[j+1][i] <= rem[j][i] - dsh;
            q[j+1][i]   <= {q[j][i][QW-2:0], 1'b1};
          end else begin
            rem[j+1][i] <= rem[j][i];
            q[j+1][i]   <= {q[j][i][QW-2:0], 1'b0};
          end
        end
        r[j+1]   <= r[j];
        neg[j+1] <= neg[j];
        dg[j+1]  <= dg[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dg[QW]) begin
        nrm[i] = '0;
      end else if (neg[QW][i]) begin
        nrm[i] = NormW'(-q[QW][i]);
      end else if (q[QW][i] > QMax) begin
        nrm[i] = NormW'(QMax);
      end else begin
        nrm[i] = NormW'(q[QW][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[QW+1] <= 1'b0;
    end else if (en) begin
      v[QW+1] <= v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal_x   <= nrm[0];
      normal_y   <= nrm[1];
      normal_z   <= nrm[2];
      degenerate <= dg[QW];
    end
  end

  assign out_valid = v[QW+1];

endmodule

// ----- rtl/triangle_face_normal_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_top
// Unit face normal of a triangle, Q12.12 vertices in, Q1.15 normal out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) takes one triangle per transaction:
//   three vertex positions, each component signed Q12.12.
//   Output channel (out_valid / out_ready) gives one transaction per
//   triangle: the unit normal of (second - first) x (third - first) in
//   signed Q1.15, plus a degenerate flag for a zero-length cross product,
//   in which case the normal is zero. Results leave in input order.
//   Throughput: one triangle per clock while in_ready is high. Every
//   stage is a register stage, and the 32-stage square root (one root
//   bit per stage) and the three 16-stage dividers (one quotient bit per
//   stage) set the depth.
//   Reset (rst, synchronous) empties the pipeline and output buffer.
//   When the receiver stalls, the result is held in the output register;
//   the next one lands in a skid register, then the whole pipeline freezes
//   and in_ready drops until the skid register drains. Nothing is lost.
// ----------------------------------------------------------------------------
module triangle_face_normal_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [tfn_pkg::CoordW-1:0] first_x,
  input  logic signed [tfn_pkg::CoordW-1:0] first_y,
  input  logic signed [tfn_pkg::CoordW-1:0] first_z,
  input  logic signed [tfn_pkg::CoordW-1:0] second_x,
  input  logic signed [tfn_pkg::CoordW-1:0] second_y,
  input  logic signed [tfn_pkg::CoordW-1:0] second_z,
  input  logic signed [tfn_pkg::CoordW-1:0] third_x,
  input  logic signed [tfn_pkg::CoordW-1:0] third_y,
  input  logic signed [tfn_pkg::CoordW-1:0] third_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tfn_pkg::NormW-1:0]  normal_x,
  output logic signed [tfn_pkg::NormW-1:0]  normal_y,
  output logic signed [tfn_pkg::NormW-1:0]  normal_z,
  output logic                              degenerate
);
  import tfn_pkg::*;

  logic                    en;
  logic                    fr_valid;
  logic [LenW-1:0]         fr_len2;
  side_t                   fr_side;
  logic                    sq_valid;
  logic [RootW-1:0]        sq_root;
  side_t                   sq_side;
  logic                    dv_valid;
  logic signed [NormW-1:0] dv_x, dv_y, dv_z;
  logic                    dv_deg;

  // skid register
  logic                    skid_valid;
  logic signed [NormW-1:0] skid_x, skid_y, skid_z;
  logic                    skid_deg;
  logic                    take;

  // advance the whole pipeline while the skid register is free
  assign en       = !skid_valid;
  assign in_ready = en;
  assign take     = out_valid && out_ready;

  tfn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .first_x   (first_x),
    .first_y   (first_y),
    .first_z   (first_z),
    .second_x  (second_x),
    .second_y  (second_y),
    .second_z  (second_z),
    .third_x   (third_x),
    .third_y   (third_y),
    .third_z   (third_z),
    .out_valid (fr_valid),
    .len2      (fr_len2),
    .side      (fr_side)
  );

  tfn_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .len2      (fr_len2),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  tfn_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (sq_valid),
    .root       (sq_root),
    .in_side    (sq_side),
    .out_valid  (dv_valid),
    .normal_x   (dv_x),
    .normal_y   (dv_y),
    .normal_z   (dv_z),
    .degenerate (dv_deg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take && skid_valid) begin
      // drain the skid register into the output register
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else if (en && dv_valid) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid) begin
      normal_x   <= skid_x;
      normal_y   <= skid_y;
      normal_z   <= skid_z;
      degenerate <= skid_deg;
    end else if (en && dv_valid) begin
      if (!out_valid || take) begin
        normal_x   <= dv_x;
        normal_y   <= dv_y;
        normal_z   <= dv_z;
        degenerate <= dv_deg;
      end else begin
        skid_x   <= dv_x;
        skid_y   <= dv_y;
        skid_z   <= dv_z;
        skid_deg <= dv_deg;
      end
    end
  end

  // a full skid register always sits behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // a degenerate triangle gives a zero normal
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
    else $error("degenerate result with nonzero normal");

  // a proper triangle never gives an all-zero normal
  a_normal_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !degenerate) |-> !(normal_x == '0 && normal_y == '0 && normal_z == '0))
    else $error("zero normal on a non-degenerate triangle");

  // a held-back result keeps the pipeline frozen for the next cycle
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_ready) |=> skid_valid && !in_ready)
    else $error("pipeline advanced while stalled");

endmodule

// ----- dv/tb_triangle_face_normal_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_face_normal_top
// Self-checking bench for the triangle face normal pipeline.
// Drives triangles over the input channel at the falling edge and computes
// the expected unit normal with exact integer arithmetic. Each output
// transaction is checked field by field against the oldest expectation.
// Idling on the sender and the receiver changes from one phase to the next.
// ----------------------------------------------------------------------------
module tb_triangle_face_normal_top;
  import tfn_pkg::*;

  typedef struct {
    logic signed [NormW-1:0] nx, ny, nz;
    logic                    deg;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CoordW-1:0] first_x = '0, first_y = '0, first_z = '0;
  logic signed [CoordW-1:0] second_x = '0, second_y = '0, second_z = '0;
  logic signed [CoordW-1:0] third_x = '0, third_y = '0, third_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [NormW-1:0] normal_x, normal_y, normal_z;
  logic degenerate;

  // Idle odds in percent for each side; the receiver process reads its own.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  normal_t     pending_normals[$];
  int unsigned error_count = 0;

  triangle_face_normal_top i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .third_x(third_x), .third_y(third_y), .third_z(third_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .degenerate(degenerate)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bitwise integer square root of a 64-bit value.
  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Compute the unit normal of one triangle.
  function automatic normal_t face_normal(logic signed [CoordW-1:0] v[9]);
    logic signed [63:0] d1[3], d2[3], c[3];
    logic [63:0] u[3], mx, len2, root, q;
    int tb;
    normal_t n;
    for (int i = 0; i < 3; i++) begin
      d1[i] = 64'(v[3+i]) - 64'(v[i]);
      d2[i] = 64'(v[6+i]) - 64'(v[i]);
    end
    c[0] = d1[1] * d2[2] - d1[2] * d2[1];
    c[1] = d1[2] * d2[0] - d1[0] * d2[2];
    c[2] = d1[0] * d2[1] - d1[1] * d2[0];
    n = '{nx: '0, ny: '0, nz: '0, deg: 1'b1};
    if (c[0] == 0 && c[1] == 0 && c[2] == 0) return n;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = c[i] < 0 ? -c[i] : c[i];
      if (u[i] > mx) mx = u[i];
    end
    tb = -1;
    while (mx != 0) begin
      mx = mx >> 1;
      tb++;
    end
    for (int i = 0; i < 3; i++) begin
      if (tb > UTop) u[i] = u[i] >> (tb - UTop);
      else u[i] = u[i] << (UTop - tb);
    end
    len2 = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    root = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      logic signed [NormW-1:0] comp;
      q = (u[i] * 64'd32768 + (root >> 1)) / root;
      if (q > 64'd32768) q = 64'd32768;
      if (c[i] < 0) comp = NormW'(-q);
      else comp = (q > 64'd32767) ? QMax : NormW'(q);
      if (i == 0) n.nx = comp;
      else if (i == 1) n.ny = comp;
      else n.nz = comp;
    end
    n.deg = 1'b0;
    return n;
  endfunction

  // Send one triangle; hold valid and payload until the transaction lands.
  // Valid stays high on return so the next triangle can follow directly.
  task automatic send_triangle(logic signed [CoordW-1:0] v[9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    {first_x, first_y, first_z} <= {v[0], v[1], v[2]};
    {second_x, second_y, second_z} <= {v[3], v[4], v[5]};
    {third_x, third_y, third_z} <= {v[6], v[7], v[8]};
    in_valid <= 1'b1;
    pending_normals.insert(pending_normals.size(), face_normal(v));
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Receiver: randomize ready at the falling edge, sample at the rising edge.
  always @(negedge clk) out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected normal %0d %0d %0d deg %0b", $time,
                 normal_x, normal_y, normal_z, degenerate);
        error_count++;
      end else begin
        normal_t e;
        e = pending_normals.pop_front();
        if (normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz ||
            degenerate !== e.deg) begin
          $display("%0t: expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                   $time, e.nx, e.ny, e.nz, e.deg,
                   normal_x, normal_y, normal_z, degenerate);
          error_count++;
        end
      end
    end
  end

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return CoordW'($urandom_range(7) - 4);        // tiny edges
      1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      2: return CoordW'($urandom_range(4095));
      default: return CoordW'($urandom);
    endcase
  endfunction

  // Extremes, degenerate shapes and axis-aligned normals, positive ones saturating.
  task automatic test_directed();
    logic signed [CoordW-1:0] v[9];
    v = '{default: '0};
    send_triangle(v);                               // all coincident
    v = '{0, 0, 0, 4096, 0, 0, 8192, 0, 0};
    send_triangle(v);                               // collinear
    v = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
    send_triangle(v);                               // +z, saturates
    v = '{0, 0, 0, 0, 4096, 0, 4096, 0, 0};
    send_triangle(v);                               // -z
    v = '{0, 0, 0, 0, 1, 0, 0, 0, 1};
    send_triangle(v);                               // +x, smallest edges
    v = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
    send_triangle(v);                               // +y
    v = '{24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000,
          24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000};
    send_triangle(v);                               // widest edges
    v = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
          24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF};
    send_triangle(v);
    v = '{0, 0, 0, 1, 1, 1, -1, -1, -1};
    send_triangle(v);                               // collinear through origin
    v = '{5, 7, 11, 13, 17, 19, 23, 29, 31};
    send_triangle(v);
    v = '{0, 0, 0, 4096, 4096, 0, 0, 4096, 4096};
    send_triangle(v);                               // equal-ish components
  endtask

  task automatic test_random(int unsigned count);
    logic signed [CoordW-1:0] v[9];
    repeat (count) begin
      for (int i = 0; i < 9; i++) v[i] = rand_coord();
      if ($urandom_range(19) == 0) for (int i = 3; i < 6; i++) v[i] = v[i-3];
      send_triangle(v);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(250);
    send_idle_pct = 76;
    test_random(200);
    send_idle_pct = 0;
    recv_stall_pct = 76;
    test_random(200);
    send_idle_pct = 22;
    recv_stall_pct = 22;
    test_random(250);
    drain();
    if (error_count == 0) $display("triangle_face_normal_top: match");
    else $display("triangle_face_normal_top: mismatch");
    $finish;
  end

  // Watchdog.
  initial begin
    #200000;
    $display("triangle_face_normal_top: mismatch");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/tfn_pkg.sv
rtl/tfn_front.sv
rtl/tfn_sqrt.sv
rtl/tfn_div.sv
rtl/triangle_face_normal_top.sv
dv/tb_triangle_face_normal_top.sv
